// ===== hdl/ttrr_pkg.sv =====
// Package for the round-robin task table: sizes, slot state and mode codes,
// and the request and response transfer types. No dependencies.
package ttrr_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int LIVE_W = $clog2(SLOTS + 1);
   localparam int ID_W = 32;
   localparam int SLOT_OUT_W = 4;
   localparam int LIVE_OUT_W = 5;

   localparam logic [1:0] ST_UNUSED = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_ZOMBIE = 2'd3;

   localparam logic [1:0] MODE_CREATE = 2'd0;
   localparam logic [1:0] MODE_TERMINATE = 2'd1;
   localparam logic [1:0] MODE_SCHEDULE = 2'd2;
   localparam logic [1:0] MODE_LOOKUP = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic entry_valid;
      logic resources_ok;
      logic [ID_W-1:0] lookup_id;
   } req_type;

   typedef struct packed {
      logic status;
      logic [ID_W-1:0] task_id;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [LIVE_OUT_W-1:0] live_count;
   } rsp_type;

endpackage

// ===== hdl/task_table_round_robin_core.sv =====
// Round-robin task table: slot state and id storage with a one-slot-per-cycle
// scan sequencer. Depends on ttrr_pkg.
//
// The scan visits one slot per cycle through a single compare unit; the response is
// loaded on the last scan cycle.
// One request at a time: a new request is taken only after the response is loaded,
// and a held response stalls the final scan cycle.
// Reset (synchronous, active high): slot 0 running with id 0, other slots
// unused, next id 1, current slot 0, no response pending.
module task_table_round_robin_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ttrr_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ttrr_pkg::rsp_type rsp_payload
);

   localparam logic SQ_IDLE = 1'b0;
   localparam logic SQ_SCAN = 1'b1;
   localparam logic [ttrr_pkg::IDX_W-1:0] LAST_IDX = ttrr_pkg::IDX_W'(ttrr_pkg::SLOTS - 1);

   logic sq_ff, sq_in;
   ttrr_pkg::req_type req_ff, req_in;
   logic [1:0] state_ff [ttrr_pkg::SLOTS];
   logic [ttrr_pkg::ID_W-1:0] id_ff [ttrr_pkg::SLOTS];
   logic [ttrr_pkg::ID_W-1:0] next_id_ff;
   logic [ttrr_pkg::IDX_W-1:0] cur_ff, idx_ff, idx_in, cnt_ff, cnt_in;
   logic [ttrr_pkg::LIVE_W-1:0] live_ff, live_in;
   logic rsp_valid_ff;
   ttrr_pkg::rsp_type rsp_ff;

   logic [1:0] scan_state;
   logic [ttrr_pkg::ID_W-1:0] scan_id;
   logic [ttrr_pkg::IDX_W-1:0] idx_next;
   logic finish, commit, out_free, res_status;
   logic [ttrr_pkg::ID_W-1:0] res_id;
   logic do_create, do_term, do_sched;

   assign scan_state = state_ff[idx_ff];
   assign scan_id = id_ff[idx_ff];
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (sq_ff == SQ_IDLE);

   always_comb begin
      finish = 1'b0;
      res_status = 1'b1;
      res_id = '0;
      do_create = 1'b0;
      do_term = 1'b0;
      do_sched = 1'b0;
      unique case (req_ff.mode)
         ttrr_pkg::MODE_CREATE: begin
            if (!req_ff.entry_valid) begin
               finish = 1'b1;
            end else if (scan_state == ttrr_pkg::ST_UNUSED ||
                         scan_state == ttrr_pkg::ST_ZOMBIE) begin
               finish = 1'b1;
               if (req_ff.resources_ok) begin
                  do_create = 1'b1;
                  res_status = 1'b0;
                  res_id = next_id_ff;
               end
            end else if (idx_ff == LAST_IDX) begin
               finish = 1'b1;
            end
         end
         ttrr_pkg::MODE_TERMINATE: begin
            finish = 1'b1;
            res_id = scan_id;
            if (idx_ff != '0) begin
               do_term = 1'b1;
               res_status = 1'b0;
            end
         end
         ttrr_pkg::MODE_SCHEDULE: begin
            if (scan_state == ttrr_pkg::ST_READY || scan_state == ttrr_pkg::ST_RUNNING) begin
               finish = 1'b1;
               do_sched = 1'b1;
               res_status = 1'b0;
               res_id = scan_id;
            end else if (cnt_ff == LAST_IDX) begin
               // last probe is the current slot itself
               finish = 1'b1;
               res_id = scan_id;
            end
         end
         ttrr_pkg::MODE_LOOKUP: begin
            if (scan_state != ttrr_pkg::ST_UNUSED && scan_id == req_ff.lookup_id) begin
               finish = 1'b1;
               res_status = 1'b0;
               res_id = scan_id;
            end else if (idx_ff == LAST_IDX) begin
               finish = 1'b1;
            end
         end
         default: finish = 1'b1;
      endcase
   end

   assign commit = (sq_ff == SQ_SCAN) && finish && out_free;

   always_comb begin
      live_in = live_ff;
      if (commit && do_create) begin
         live_in = live_ff + 1'b1;
      end else if (commit && do_term &&
                   (scan_state == ttrr_pkg::ST_READY || scan_state == ttrr_pkg::ST_RUNNING)) begin
         live_in = live_ff - 1'b1;
      end
   end

   always_comb begin
      sq_in = sq_ff;
      req_in = req_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      priority if (sq_ff == SQ_IDLE && req_valid) begin
         sq_in = SQ_SCAN;
         req_in = req_payload;
         cnt_in = '0;
         unique case (req_payload.mode)
            ttrr_pkg::MODE_CREATE: idx_in = ttrr_pkg::IDX_W'(1);
            ttrr_pkg::MODE_TERMINATE: idx_in = cur_ff;
            ttrr_pkg::MODE_SCHEDULE: idx_in = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;
            ttrr_pkg::MODE_LOOKUP: idx_in = '0;
            default: idx_in = '0;
         endcase
      end else if (commit) begin
         sq_in = SQ_IDLE;
      end else if (sq_ff == SQ_SCAN && !finish) begin
         idx_in = idx_next;
         cnt_in = cnt_ff + 1'b1;
      end else begin
         sq_in = sq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff <= SQ_IDLE;
         rsp_valid_ff <= 1'b0;
         next_id_ff <= ttrr_pkg::ID_W'(1);
         cur_ff <= '0;
         live_ff <= ttrr_pkg::LIVE_W'(1);
         for (int i = 0; i < ttrr_pkg::SLOTS; i++) begin
            state_ff[i] <= (i == 0) ? ttrr_pkg::ST_RUNNING : ttrr_pkg::ST_UNUSED;
            id_ff[i] <= '0;
         end
      end else begin
         sq_ff <= sq_in;
         live_ff <= live_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit && do_create) begin
            state_ff[idx_ff] <= ttrr_pkg::ST_READY;
            id_ff[idx_ff] <= next_id_ff;
            next_id_ff <= next_id_ff + 1'b1;
         end
         if (commit && do_term) begin
            state_ff[idx_ff] <= ttrr_pkg::ST_ZOMBIE;
         end
         if (commit && do_sched) begin
            state_ff[idx_ff] <= ttrr_pkg::ST_RUNNING;
            cur_ff <= idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (commit) begin
         rsp_ff.status <= res_status;
         rsp_ff.task_id <= res_id;
         rsp_ff.slot_index <= res_status ?
            ((req_ff.mode == ttrr_pkg::MODE_TERMINATE || req_ff.mode == ttrr_pkg::MODE_SCHEDULE) ?
             ttrr_pkg::SLOT_OUT_W'(idx_ff) : '0) :
            ttrr_pkg::SLOT_OUT_W'(idx_ff);
         rsp_ff.live_count <= ttrr_pkg::LIVE_OUT_W'(live_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // boot slot is never retired
   a_boot_running: assert property (@(posedge clock) disable iff (reset)
      state_ff[0] == ttrr_pkg::ST_RUNNING)
      else $error("boot slot left running state");

   a_live_nonzero: assert property (@(posedge clock) disable iff (reset)
      live_ff != '0)
      else $error("live count reached zero");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while a transfer is in progress");

   a_commit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid)
      else $error("finished scan produced no response");
`endif

endmodule

// ===== dv/tb_task_table_round_robin_core.sv =====
// Self-checking testbench for task_table_round_robin_core: a queue-fed driver, a response
// monitor and a cycle-free task table predictor that checks every response transfer.
// Depends on ttrr_pkg and the task_table_round_robin_core RTL.
module tb_task_table_round_robin_core;

   localparam int GROW = 0;
   localparam int SHRINK = 1;
   localparam int MIXED = 2;
   localparam int RANDOM_ITEMS = 1900;
   localparam int BLOCK_ITEMS = 100;

   typedef struct {
      ttrr_pkg::req_type rq;
      bit drain;
   } staged_req_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ttrr_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ttrr_pkg::rsp_type rsp_payload;

   staged_req_type req_q[$];
   ttrr_pkg::rsp_type rsp_q[$];

   // predictor state
   logic [1:0] tbl_state[ttrr_pkg::SLOTS];
   logic [ttrr_pkg::ID_W-1:0] tbl_id[ttrr_pkg::SLOTS];
   logic [ttrr_pkg::ID_W-1:0] id_next;
   logic [31:0] cur_slot;

   int errors = 0;
   int n_xfer = 0, n_create = 0, n_refused = 0, n_term = 0, n_boot_term = 0;
   int n_sched = 0, n_lookup = 0, n_missed = 0, peak_live = 0;
   int drv_gap = 0, drv_burst = 0, mon_stall = 0, mon_calm = 0;

   task_table_round_robin_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit slot_live(int s);
      return tbl_state[s] == ttrr_pkg::ST_READY || tbl_state[s] == ttrr_pkg::ST_RUNNING;
   endfunction

   function automatic ttrr_pkg::rsp_type table_step(ttrr_pkg::req_type rq);
      ttrr_pkg::rsp_type r;
      int s;
      int live;
      int idx;
      bit done;
      r = '0;
      r.status = 1'b1;
      done = 1'b0;
      n_xfer++;
      case (rq.mode)
         ttrr_pkg::MODE_CREATE: begin
            n_create++;
            if (rq.entry_valid) begin
               for (s = 1; s < ttrr_pkg::SLOTS; s++) begin
                  if (!done && (tbl_state[s] == ttrr_pkg::ST_UNUSED ||
                                tbl_state[s] == ttrr_pkg::ST_ZOMBIE)) begin
                     done = 1'b1;
                     if (rq.resources_ok) begin
                        tbl_id[s] = id_next;
                        id_next = id_next + 1'b1;
                        tbl_state[s] = ttrr_pkg::ST_READY;
                        r.status = 1'b0;
                        r.task_id = tbl_id[s];
                        r.slot_index = s[ttrr_pkg::SLOT_OUT_W-1:0];
                     end
                  end
               end
            end
            if (r.status) n_refused++;
         end
         ttrr_pkg::MODE_TERMINATE: begin
            n_term++;
            if (cur_slot != 0) begin
               tbl_state[cur_slot] = ttrr_pkg::ST_ZOMBIE;
               r.status = 1'b0;
            end else begin
               n_boot_term++;
            end
            r.task_id = tbl_id[cur_slot];
            r.slot_index = cur_slot[ttrr_pkg::SLOT_OUT_W-1:0];
         end
         ttrr_pkg::MODE_SCHEDULE: begin
            n_sched++;
            for (s = 1; s <= ttrr_pkg::SLOTS; s++) begin
               idx = (cur_slot + s) % ttrr_pkg::SLOTS;
               if (!done && slot_live(idx)) begin
                  done = 1'b1;
                  cur_slot = idx;
                  tbl_state[idx] = ttrr_pkg::ST_RUNNING;
                  r.status = 1'b0;
               end
            end
            r.task_id = tbl_id[cur_slot];
            r.slot_index = cur_slot[ttrr_pkg::SLOT_OUT_W-1:0];
         end
         default: begin
            n_lookup++;
            for (s = 0; s < ttrr_pkg::SLOTS; s++) begin
               if (!done && tbl_state[s] != ttrr_pkg::ST_UNUSED &&
                   tbl_id[s] == rq.lookup_id) begin
                  done = 1'b1;
                  r.status = 1'b0;
                  r.task_id = tbl_id[s];
                  r.slot_index = s[ttrr_pkg::SLOT_OUT_W-1:0];
               end
            end
            if (r.status) n_missed++;
         end
      endcase
      live = 0;
      for (s = 0; s < ttrr_pkg::SLOTS; s++)
         if (slot_live(s)) live++;
      if (live > peak_live) peak_live = live;
      r.live_count = live[ttrr_pkg::LIVE_OUT_W-1:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic ttrr_pkg::req_type gen_req(int profile, int id_top);
      ttrr_pkg::req_type rq;
      int r;
      r = $urandom_range(0, 99);
      rq.lookup_id = $urandom();
      rq.entry_valid = $urandom_range(0, 9) != 0;
      rq.resources_ok = $urandom_range(0, 9) != 0;
      case (profile)
         GROW: rq.mode = (r < 55) ? ttrr_pkg::MODE_CREATE :
                         (r < 65) ? ttrr_pkg::MODE_TERMINATE :
                         (r < 85) ? ttrr_pkg::MODE_SCHEDULE : ttrr_pkg::MODE_LOOKUP;
         SHRINK: rq.mode = (r < 10) ? ttrr_pkg::MODE_CREATE :
                           (r < 50) ? ttrr_pkg::MODE_TERMINATE :
                           (r < 85) ? ttrr_pkg::MODE_SCHEDULE : ttrr_pkg::MODE_LOOKUP;
         default: rq.mode = (r < 30) ? ttrr_pkg::MODE_CREATE :
                            (r < 50) ? ttrr_pkg::MODE_TERMINATE :
                            (r < 80) ? ttrr_pkg::MODE_SCHEDULE : ttrr_pkg::MODE_LOOKUP;
      endcase
      if (rq.mode == ttrr_pkg::MODE_LOOKUP && $urandom_range(0, 9) < 7)
         rq.lookup_id = $urandom_range(0, id_top);
      return rq;
   endfunction

   task automatic push_req(logic [1:0] mode, logic ev, logic rok,
                           logic [ttrr_pkg::ID_W-1:0] id, bit drain);
      staged_req_type item;
      item.rq.mode = mode;
      item.rq.entry_valid = ev;
      item.rq.resources_ok = rok;
      item.rq.lookup_id = id;
      item.drain = drain;
      req_q.push_back(item);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin : drive
      logic fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            rsp_q.push_back(table_step(req_payload));
            req_q.delete(0);
            if (drv_burst != 0) begin
               drv_burst--;
               drv_gap = 0;
            end else begin
               drv_gap = pick_gap();
               if ($urandom_range(0, 29) == 0) drv_burst = 40;
            end
         end
         if (req_valid && !fire) begin
            // hold until transfer
         end else if (drv_gap != 0) begin
            drv_gap--;
            req_valid <= 1'b0;
         end else if (req_q.size() != 0 && (!req_q[0].drain || rsp_q.size() == 0)) begin
            req_valid <= 1'b1;
            req_payload <= req_q[0].rq;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      ttrr_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_q.size() == 0) begin
               $display("%0t: response with none expected: actual %0h", $time, rsp_payload);
               errors++;
            end else begin
               want = rsp_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_payload.status));
               check_field("task_id", want.task_id, rsp_payload.task_id);
               check_field("slot_index", 32'(want.slot_index), 32'(rsp_payload.slot_index));
               check_field("live_count", 32'(want.live_count), 32'(rsp_payload.live_count));
            end
         end
         if (mon_calm != 0) mon_calm--;
         else if ($urandom_range(0, 199) == 0) mon_calm = 100;
         if (mon_stall == 0 && mon_calm == 0 && $urandom_range(0, 3) == 0)
            mon_stall = pick_gap();
         if (mon_stall != 0) begin
            mon_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int i;
      int profile;
      int ids_made;
      staged_req_type item;
      for (i = 0; i < ttrr_pkg::SLOTS; i++) begin
         tbl_state[i] = ttrr_pkg::ST_UNUSED;
         tbl_id[i] = '0;
      end
      tbl_state[0] = ttrr_pkg::ST_RUNNING;
      id_next = 1;
      cur_slot = 0;

      // directed: boot-only table, refused creates, full table, zombie reuse
      push_req(ttrr_pkg::MODE_LOOKUP, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
      push_req(ttrr_pkg::MODE_LOOKUP, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
      push_req(ttrr_pkg::MODE_TERMINATE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
      push_req(ttrr_pkg::MODE_SCHEDULE, 1'b0, 1'b1, 32'h0000_0000, 1'b0);
      push_req(ttrr_pkg::MODE_CREATE, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
      push_req(ttrr_pkg::MODE_CREATE, 1'b1, 1'b0, 32'h0000_0000, 1'b0);
      for (i = 1; i < ttrr_pkg::SLOTS; i++)
         push_req(ttrr_pkg::MODE_CREATE, 1'b1, 1'b1, $urandom(), 1'b0);
      push_req(ttrr_pkg::MODE_CREATE, 1'b1, 1'b1, 32'hA5A5_5A5A, 1'b0);
      push_req(ttrr_pkg::MODE_SCHEDULE, 1'b1, 1'b0, 32'h5A5A_A5A5, 1'b0);
      push_req(ttrr_pkg::MODE_TERMINATE, 1'b0, 1'b0, 32'h0000_0001, 1'b0);
      push_req(ttrr_pkg::MODE_LOOKUP, 1'b1, 1'b0, 32'h0000_0001, 1'b0);
      push_req(ttrr_pkg::MODE_CREATE, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
      ids_made = ttrr_pkg::SLOTS;

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % BLOCK_ITEMS == 0) profile = $urandom_range(GROW, MIXED);
         item.rq = gen_req(profile, ids_made + 2);
         item.drain = (i % BLOCK_ITEMS == 0);
         if (item.rq.mode == ttrr_pkg::MODE_CREATE && item.rq.entry_valid &&
             item.rq.resources_ok)
            ids_made++;
         req_q.push_back(item);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_q.size() != 0 || rsp_q.size() != 0) @(posedge clock);
      repeat (3 * (ttrr_pkg::SLOTS + 2)) @(posedge clock);

      $display("Covered %0d transfers: %0d creates (%0d refused), %0d terminates (%0d on boot),",
               n_xfer, n_create, n_refused, n_term, n_boot_term);
      $display("%0d schedules, %0d lookups (%0d missed), peak live count %0d.",
               n_sched, n_lookup, n_missed, peak_live);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #16_000_000;
      $display("Timeout with %0d requests and %0d responses outstanding",
               req_q.size(), rsp_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
